// ----- rtl/core/bcc_pkg.sv -----
// ----------------------------------------------------------------------------
// bcc_pkg
// shared types and constants of the button click classifier
// ----------------------------------------------------------------------------
package bcc_pkg;

	localparam int unsigned TIMER_W    = 16;
	localparam int unsigned LEVEL_BITS = 3;
	localparam int unsigned IDX_W      = 2;
	localparam int unsigned CODE_W     = 2;
	localparam int unsigned REG_IDX_W  = 2;

	localparam logic [TIMER_W-1:0] TIMER_MAX = 16'hffff;

	localparam logic [TIMER_W-1:0] DEBOUNCE_RST = 16'd20;
	localparam logic [TIMER_W-1:0] DOUBLE_RST   = 16'd500;
	localparam logic [TIMER_W-1:0] LONG_RST     = 16'd1000;

	typedef enum logic [0:0] {
		CMD_TICK = 1'b0,
		CMD_READ = 1'b1
	} cmd_t;

	typedef enum logic [CODE_W-1:0] {
		EV_NONE   = 2'd0,
		EV_SINGLE = 2'd1,
		EV_DOUBLE = 2'd2,
		EV_LONG   = 2'd3
	} event_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_DEBOUNCE = 2'd0,
		REG_DOUBLE   = 2'd1,
		REG_LONG     = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic                  command;
		logic [LEVEL_BITS-1:0] key_levels;
		logic [IDX_W-1:0]      key_index;
	} in_item_t;

	typedef struct packed {
		logic [CODE_W-1:0]     event_code;
		logic [LEVEL_BITS-1:0] pending_mask;
	} out_item_t;

	typedef struct packed {
		logic [TIMER_W-1:0] debounce_ticks;
		logic [TIMER_W-1:0] double_click_ticks;
		logic [TIMER_W-1:0] long_press_ticks;
	} cfg_t;

	// per-lane command, already qualified by the input transfer
	typedef struct packed {
		logic tick;
		logic down;
		logic rd;
	} lane_cmd_t;

	typedef struct packed {
		logic              pend_next;
		logic [CODE_W-1:0] rd_code;
	} lane_stat_t;

endpackage

// ----- rtl/core/bcc_key_lane.sv -----
// ----------------------------------------------------------------------------
// bcc_key_lane
// per-key click state machine with debounce, double-click and long-press timer
// ----------------------------------------------------------------------------
module bcc_key_lane
	import bcc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  lane_cmd_t  cmd,
	output lane_stat_t stat
);

	typedef enum logic [2:0] {
		PH_RELEASED = 3'd0,
		PH_DEBOUNCE = 3'd1,
		PH_PRESSED  = 3'd2,
		PH_WAIT2    = 3'd3,
		PH_LONG     = 3'd4,
		PH_IGNORE   = 3'd5
	} phase_t;

	phase_t             phase_q, phase_d;
	logic [TIMER_W-1:0] timer_q, timer_d, timer_inc;
	logic               pend_q, pend_d;
	event_t             latched_q, latched_d;
	logic               click_q, click_d;

	assign timer_inc = (timer_q == TIMER_MAX) ? TIMER_MAX : timer_q + 16'd1;

	always_comb begin
		phase_d   = phase_q;
		timer_d   = timer_q;
		pend_d    = pend_q;
		latched_d = latched_q;
		click_d   = click_q;
		if (cmd.tick) begin
			case (phase_q)
				PH_RELEASED: begin
					if (cmd.down) begin
						phase_d = PH_DEBOUNCE;
						timer_d = '0;
					end
				end
				PH_DEBOUNCE: begin
					if (cmd.down) begin
						timer_d = timer_inc;
						if (timer_inc >= cfg.debounce_ticks) begin
							phase_d = PH_PRESSED;
							timer_d = '0;
						end
					end else begin
						phase_d = PH_RELEASED;
					end
				end
				PH_PRESSED: begin
					if (cmd.down) begin
						timer_d = timer_inc;
						if (timer_inc >= cfg.long_press_ticks && !pend_q) begin
							latched_d = EV_LONG;
							pend_d    = 1'b1;
							click_d   = 1'b0;
							phase_d   = PH_LONG;
						end
					end else if (timer_q < cfg.long_press_ticks) begin
						phase_d = PH_WAIT2;
						timer_d = '0;
						click_d = 1'b1;
					end else begin
						phase_d = PH_RELEASED;
					end
				end
				PH_WAIT2: begin
					if (cmd.down) begin
						if (timer_q <= cfg.double_click_ticks && click_q) begin
							latched_d = EV_DOUBLE;
							pend_d    = 1'b1;
							click_d   = 1'b0;
							phase_d   = PH_IGNORE;
						end else begin
							phase_d = PH_DEBOUNCE;
							timer_d = '0;
							click_d = 1'b0;
						end
					end else begin
						timer_d = timer_inc;
						if (timer_inc > cfg.double_click_ticks) begin
							if (click_q) begin
								latched_d = EV_SINGLE;
								pend_d    = 1'b1;
							end
							phase_d = PH_RELEASED;
						end
					end
				end
				PH_LONG, PH_IGNORE: begin
					if (!cmd.down) begin
						phase_d = PH_RELEASED;
					end
				end
				default: begin
					phase_d = PH_RELEASED;
				end
			endcase
		end else if (cmd.rd && pend_q) begin
			pend_d    = 1'b0;
			latched_d = EV_NONE;
		end
	end

	assign stat.pend_next = pend_d;
	assign stat.rd_code   = (cmd.rd && pend_q) ? latched_q : EV_NONE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_RELEASED;
			timer_q   <= '0;
			pend_q    <= 1'b0;
			latched_q <= EV_NONE;
			click_q   <= 1'b0;
		end else begin
			phase_q   <= phase_d;
			timer_q   <= timer_d;
			pend_q    <= pend_d;
			latched_q <= latched_d;
			click_q   <= click_d;
		end
	end

endmodule

// ----- rtl/core/bcc_merge.sv -----
// ----------------------------------------------------------------------------
// bcc_merge
// combines lane status into the result item and holds the output register
// ----------------------------------------------------------------------------
module bcc_merge
	import bcc_pkg::*;
#(
	parameter int unsigned NUM_KEYS = 3
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	output logic                      in_xfer,
	input  lane_stat_t [NUM_KEYS-1:0] stat,
	output logic                      out_valid,
	input  logic                      out_ready,
	output out_item_t                 out_item
);

	out_item_t             res_d;
	logic [CODE_W-1:0]     code_any;
	logic [LEVEL_BITS-1:0] mask_d;
	logic                  out_valid_q;
	out_item_t             out_item_q;

	assign in_ready = !out_valid_q || out_ready;
	assign in_xfer  = in_valid && in_ready;

	// at most one lane drives a nonzero read code
	always_comb begin
		code_any = EV_NONE;
		for (int k = 0; k < NUM_KEYS; k++) begin
			code_any = code_any | stat[k].rd_code;
		end
	end

	for (genvar b = 0; b < LEVEL_BITS; b++) begin : g_mask
		if (b < NUM_KEYS) begin : g_on
			assign mask_d[b] = stat[b].pend_next;
		end else begin : g_off
			assign mask_d[b] = 1'b0;
		end
	end

	assign res_d.event_code   = code_any;
	assign res_d.pending_mask = mask_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_xfer) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			out_item_q <= res_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

// ----- rtl/core/button_click_classifier_unit.sv -----
// ----------------------------------------------------------------------------
// button_click_classifier_unit
// single, double and long press classifier for a row of buttons
// ----------------------------------------------------------------------------
// Items enter on in_valid/in_ready. A tick item advances every key by one
// tick using key_levels; a read item returns the latched event of key_index
// and clears it. Each item gives exactly one result on out_valid/out_ready:
// event_code (zero on tick) and the mask of keys with unread events.
// The result is captured in the output register at the transfer. Throughput
// is one item per cycle while out_ready keeps up, set by one key state
// update per lane per cycle; all keys run as parallel lanes.
// While a result waits and out_ready is low, in_ready is low and the result
// holds; a result that is taken in the same cycle frees room for a new item.
// Registers are written through cfg_we/cfg_index/cfg_wdata with no wait;
// index 3 is ignored. Reset puts every key in the released phase, clears
// timers and events, and loads debounce 20, double-click 500, long 1000.
// ----------------------------------------------------------------------------
module button_click_classifier_unit
	import bcc_pkg::*;
#(
	parameter int unsigned NUM_KEYS = 3
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_item_t             in_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_item_t            out_item,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [TIMER_W-1:0]   cfg_wdata
);

	cfg_t                      cfg_q;
	logic                      in_xfer;
	lane_cmd_t  [NUM_KEYS-1:0] lane_cmd;
	lane_stat_t [NUM_KEYS-1:0] lane_stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks     <= DEBOUNCE_RST;
			cfg_q.double_click_ticks <= DOUBLE_RST;
			cfg_q.long_press_ticks   <= LONG_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEBOUNCE: cfg_q.debounce_ticks     <= cfg_wdata;
				REG_DOUBLE:   cfg_q.double_click_ticks <= cfg_wdata;
				REG_LONG:     cfg_q.long_press_ticks   <= cfg_wdata;
				default:      ;
			endcase
		end
	end

	for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
		if (k < LEVEL_BITS) begin : g_lvl
			assign lane_cmd[k].down = in_item.key_levels[k];
		end else begin : g_nolvl
			assign lane_cmd[k].down = 1'b0;
		end
		assign lane_cmd[k].tick = in_xfer && (in_item.command == CMD_TICK);
		assign lane_cmd[k].rd   = in_xfer && (in_item.command == CMD_READ)
			&& (32'(in_item.key_index) == 32'(k));

		bcc_key_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.cfg    (cfg_q),
			.cmd    (lane_cmd[k]),
			.stat   (lane_stat[k])
		);
	end

	bcc_merge #(
		.NUM_KEYS (NUM_KEYS)
	) u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_xfer   (in_xfer),
		.stat      (lane_stat),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

// ----- rtl/core/bcc_checker.sv -----
// ----------------------------------------------------------------------------
// bcc_checker
// port-level checks of the button click classifier
// ----------------------------------------------------------------------------
module bcc_checker
	import bcc_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input in_item_t  in_item,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_item
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("stalled result changed");

	// every transfer gives a result on the next cycle
	a_in_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("transfer gave no result");

	// a tick never reports an event
	a_tick_none: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_item.command == CMD_TICK
		|=> out_item.event_code == EV_NONE)
		else $error("tick returned an event");

	// empty output register always takes an item
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("not ready with empty output");

endmodule

bind button_click_classifier_unit bcc_checker u_bcc_checker (.*);

// ----- tb/button_click_classifier_unit_test.sv -----
// ----------------------------------------------------------------------------
// button_click_classifier_unit_test
// self-checking bench for the single, double and long press classifier
// ----------------------------------------------------------------------------
// A driver streams tick and read items from a queue over the input channel.
// Each transfer runs through a cycle-level copy of the per-key press
// machines, and the predicted report is queued. A monitor pops one report
// per output transfer and compares event code and pending mask. Both sides
// insert random gaps. Thresholds are changed between phases once the block
// is drained: a directed pass, then random phases of press and release runs
// mixed with reads and level noise.
// ----------------------------------------------------------------------------
module button_click_classifier_unit_test;
	import bcc_pkg::*;

	localparam int unsigned NUM_KEYS = 3;
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;

	typedef enum logic [2:0] {
		KEY_RELEASED,
		KEY_DEBOUNCE,
		KEY_PRESSED,
		KEY_WAIT2,
		KEY_LONG,
		KEY_IGNORE
	} key_state_t;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	in_item_t             in_item = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	out_item_t            out_item;
	logic                 cfg_we = 1'b0;
	logic [REG_IDX_W-1:0] cfg_index = '0;
	logic [TIMER_W-1:0]   cfg_wdata = '0;

	// press machine copy
	cfg_t               thresholds;
	key_state_t         key_state [NUM_KEYS];
	logic [TIMER_W-1:0] key_timer [NUM_KEYS];
	logic               event_pend [NUM_KEYS];
	event_t             event_held [NUM_KEYS];
	logic               click_open [NUM_KEYS];

	in_item_t  key_item_q[$];
	out_item_t report_q[$];
	out_item_t want;

	bit quiet = 1'b0;
	int send_gap = 0;
	int take_gap = 0;
	int errors = 0;
	int items_sent = 0;
	int reports_checked = 0;
	int n_single = 0;
	int n_double = 0;
	int n_long = 0;
	int cycle_count = 0;

	button_click_classifier_unit #(.NUM_KEYS(NUM_KEYS)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) cycle_count++;

	function automatic int idle_len();
		int r;
		if (quiet) return 0;
		r = $urandom_range(99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(3, 1);
		if (r < 98) return $urandom_range(12, 4);
		return $urandom_range(60, 20);
	endfunction

	function automatic out_item_t classify_item(in_item_t it);
		out_item_t rep;
		logic down;
		int k;
		rep = '0;
		rep.event_code = EV_NONE;
		if (it.command == CMD_TICK) begin
			for (k = 0; k < NUM_KEYS; k++) begin
				down = (k < LEVEL_BITS) ? it.key_levels[k] : 1'b0;
				case (key_state[k])
					KEY_RELEASED: begin
						if (down) begin
							key_state[k] = KEY_DEBOUNCE;
							key_timer[k] = '0;
						end
					end
					KEY_DEBOUNCE: begin
						if (down) begin
							if (key_timer[k] != TIMER_MAX) key_timer[k]++;
							if (key_timer[k] >= thresholds.debounce_ticks) begin
								key_state[k] = KEY_PRESSED;
								key_timer[k] = '0;
							end
						end else begin
							key_state[k] = KEY_RELEASED;
						end
					end
					KEY_PRESSED: begin
						if (down) begin
							if (key_timer[k] != TIMER_MAX) key_timer[k]++;
							if (key_timer[k] >= thresholds.long_press_ticks && !event_pend[k]) begin
								event_held[k] = EV_LONG;
								event_pend[k] = 1'b1;
								click_open[k] = 1'b0;
								key_state[k] = KEY_LONG;
							end
						end else if (key_timer[k] < thresholds.long_press_ticks) begin
							key_state[k] = KEY_WAIT2;
							key_timer[k] = '0;
							click_open[k] = 1'b1;
						end else begin
							key_state[k] = KEY_RELEASED;
						end
					end
					KEY_WAIT2: begin
						if (down) begin
							if (key_timer[k] <= thresholds.double_click_ticks && click_open[k]) begin
								event_held[k] = EV_DOUBLE;
								event_pend[k] = 1'b1;
								click_open[k] = 1'b0;
								key_state[k] = KEY_IGNORE;
							end else begin
								key_state[k] = KEY_DEBOUNCE;
								key_timer[k] = '0;
								click_open[k] = 1'b0;
							end
						end else begin
							if (key_timer[k] != TIMER_MAX) key_timer[k]++;
							if (key_timer[k] > thresholds.double_click_ticks) begin
								if (click_open[k]) begin
									event_held[k] = EV_SINGLE;
									event_pend[k] = 1'b1;
								end
								key_state[k] = KEY_RELEASED;
							end
						end
					end
					default: begin
						if (!down) key_state[k] = KEY_RELEASED;
					end
				endcase
			end
		end else if (it.key_index < NUM_KEYS) begin
			if (event_pend[it.key_index]) begin
				event_pend[it.key_index] = 1'b0;
				rep.event_code = event_held[it.key_index];
				event_held[it.key_index] = EV_NONE;
			end
		end
		for (k = 0; k < NUM_KEYS && k < LEVEL_BITS; k++)
			rep.pending_mask[k] = event_pend[k];
		return rep;
	endfunction

	task automatic push_tick(logic [LEVEL_BITS-1:0] levels);
		in_item_t it;
		it.command = CMD_TICK;
		it.key_levels = levels;
		it.key_index = IDX_W'($urandom);
		key_item_q.push_back(it);
	endtask

	task automatic push_read(logic [IDX_W-1:0] idx);
		in_item_t it;
		it.command = CMD_READ;
		it.key_levels = LEVEL_BITS'($urandom);
		it.key_index = idx;
		key_item_q.push_back(it);
	endtask

	// only called with the block drained
	task automatic set_thresholds(logic [TIMER_W-1:0] deb, logic [TIMER_W-1:0] dbl,
			logic [TIMER_W-1:0] lng);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_DEBOUNCE;
		cfg_wdata <= deb;
		@(posedge clk);
		cfg_index <= REG_DOUBLE;
		cfg_wdata <= dbl;
		@(posedge clk);
		cfg_index <= REG_LONG;
		cfg_wdata <= lng;
		@(posedge clk);
		cfg_index <= REG_SPARE;
		cfg_wdata <= TIMER_W'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
		thresholds.debounce_ticks = deb;
		thresholds.double_click_ticks = dbl;
		thresholds.long_press_ticks = lng;
	endtask

	// sampled on the falling edge so the driver and monitor updates have settled
	task automatic wait_drained();
		@(negedge clk);
		while (key_item_q.size() != 0 || in_valid || report_q.size() != 0)
			@(negedge clk);
		repeat (3) @(posedge clk);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_item <= '0;
		end else begin
			if (in_valid && in_ready) begin
				report_q.push_back(classify_item(in_item));
				items_sent++;
			end
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (key_item_q.size() > 0) begin
					in_item <= key_item_q.pop_front();
					in_valid <= 1'b1;
					send_gap = idle_len();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (report_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected transfer, expected none, got event_code %0d pending_mask %b",
						$time, out_item.event_code, out_item.pending_mask);
				end else begin
					want = report_q.pop_front();
					reports_checked++;
					if (out_item.event_code !== want.event_code) begin
						errors++;
						$display("%0t: event_code expected %0d got %0d",
							$time, want.event_code, out_item.event_code);
					end
					if (out_item.pending_mask !== want.pending_mask) begin
						errors++;
						$display("%0t: pending_mask expected %b got %b",
							$time, want.pending_mask, out_item.pending_mask);
					end
					case (want.event_code)
						EV_SINGLE: n_single++;
						EV_DOUBLE: n_double++;
						EV_LONG:   n_long++;
						default:   ;
					endcase
				end
			end
			if (take_gap > 0) begin
				take_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				take_gap = idle_len();
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) @(posedge clk);
		$display("button_click_classifier_unit_test failed");
		$finish;
	end

	initial begin
		int p;
		int n;
		int r;
		int k;
		int maxdur;
		int hold [NUM_KEYS];
		logic [LEVEL_BITS-1:0] lv;
		logic [TIMER_W-1:0] deb;
		logic [TIMER_W-1:0] dbl;
		logic [TIMER_W-1:0] lng;

		thresholds.debounce_ticks = DEBOUNCE_RST;
		thresholds.double_click_ticks = DOUBLE_RST;
		thresholds.long_press_ticks = LONG_RST;
		for (k = 0; k < NUM_KEYS; k++) begin
			key_state[k] = KEY_RELEASED;
			key_timer[k] = '0;
			event_pend[k] = 1'b0;
			event_held[k] = EV_NONE;
			click_open[k] = 1'b0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// reset thresholds: empty reads, out of range read, all keys bouncing
		push_read(2'd0);
		push_read(2'd3);
		push_tick(3'b111);
		push_tick(3'b000);
		wait_drained();

		// zero debounce: double on key 0, long on key 1, single on key 2
		set_thresholds(16'd0, 16'd2, 16'd4);
		push_tick(3'b011);
		push_tick(3'b011);
		push_tick(3'b010);
		push_tick(3'b011);
		push_tick(3'b010);
		push_tick(3'b110);
		push_tick(3'b100);
		push_tick(3'b000);
		push_tick(3'b000);
		push_tick(3'b000);
		push_tick(3'b000);
		push_read(2'd0);
		push_read(2'd1);
		push_read(2'd2);
		push_read(2'd3);
		push_read(2'd0);
		wait_drained();

		for (p = 0; p < 12; p++) begin
			deb = TIMER_W'($urandom_range(4));
			dbl = TIMER_W'($urandom_range(8));
			lng = TIMER_W'($urandom_range(14));
			if (p == 0) deb = 16'hffff;
			if (p == 1) begin
				deb = '0;
				dbl = '0;
				lng = '0;
			end
			if (p == 2) dbl = 16'hfffe;
			quiet = (p % 4 == 3);
			set_thresholds(deb, dbl, lng);
			maxdur = deb + dbl + lng + 4;
			if (maxdur > 30) maxdur = 30;
			lv = '0;
			for (k = 0; k < NUM_KEYS; k++)
				hold[k] = $urandom_range(maxdur, 1);
			for (n = 0; n < 120; n++) begin
				r = $urandom_range(99);
				if (r < 18) begin
					push_read(IDX_W'($urandom_range(3)));
				end else if (r < 24) begin
					push_tick(LEVEL_BITS'($urandom));
				end else begin
					for (k = 0; k < NUM_KEYS; k++) begin
						hold[k]--;
						if (hold[k] == 0) begin
							lv[k] = ~lv[k];
							hold[k] = $urandom_range(maxdur, 1);
						end
					end
					push_tick(lv);
				end
			end
			wait_drained();
		end

		$display("%0d items sent, %0d reports checked over 14 threshold settings",
			items_sent, reports_checked);
		$display("events read back: %0d single, %0d double, %0d long",
			n_single, n_double, n_long);
		if (errors == 0 && report_q.size() == 0)
			$display("button_click_classifier_unit_test passed");
		else
			$display("button_click_classifier_unit_test failed");
		$finish;
	end

endmodule
